### rtl/core/tcon_pkg.sv
// Shared types, constants and codes of the text console with scrollback.
package tcon_pkg;

    localparam int MAX_ROWS_DEF      = 64;
    localparam int MAX_COLS_DEF      = 128;
    localparam int HISTORY_LINES_DEF = 1024;

    localparam int CMD_W      = 3;
    localparam int CHAR_W     = 8;
    localparam int COLOUR_W   = 8;
    localparam int VROW_W     = 6;
    localparam int VCOL_W     = 7;
    localparam int CROW_W     = 6;
    localparam int CCOL_W     = 7;
    localparam int VOFF_W     = 11;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int IW_W       = 8;
    localparam int IH_W       = 7;
    localparam logic [IW_W-1:0] WIDTH_RST  = 8'd80;
    localparam logic [IH_W-1:0] HEIGHT_RST = 7'd24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_COLS = 1'b0,
        CFG_WIN_ROWS = 1'b1
    } t_cfg_idx;

    localparam logic [CMD_W-1:0] CMD_PUT_CHAR   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_VIEW_UP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_VIEW_DOWN  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_VIEW_RESET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_CELL  = 3'd4;

    localparam logic [CHAR_W-1:0] CH_BS       = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'd13;
    localparam logic [CHAR_W-1:0] CH_DEL      = 8'd127;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd126;
    localparam int TAB_STEP = 8;

    localparam logic [CHAR_W-1:0]   BLANK_CHAR = 8'd32;
    localparam logic [COLOUR_W-1:0] BLANK_FORE = 8'd7;
    localparam logic [COLOUR_W-1:0] BLANK_BACK = 8'd0;

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic [COLOUR_W-1:0] fg;
        logic [COLOUR_W-1:0] bg;
    } t_cell;

    localparam t_cell BLANK_CELL = '{ch: BLANK_CHAR, fg: BLANK_FORE, bg: BLANK_BACK};

    typedef enum logic [1:0] {
        KIND_STEP,
        KIND_TAB,
        KIND_READ
    } t_kind;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_CAPTURE,
        OP_STEP,
        OP_TAB_INIT,
        OP_TAB_WR,
        OP_TAB_END,
        OP_READ,
        OP_ROW_INC,
        OP_SCROLL_BEGIN,
        OP_HIST_RD,
        OP_HIST_WR,
        OP_MOVE_RD,
        OP_MOVE_WR,
        OP_BLANK,
        OP_RESULT
    } t_op;

    typedef struct packed {
        logic  clear_last;
        t_kind kind;
        logic  tab_more;
        logic  pend_row;
        logic  scroll_need;
        logic  hist_last;
        logic  single_row;
        logic  move_last;
        logic  blank_last;
        logic  out_free;
    } t_status;

endpackage

### rtl/core/tcon_ctrl.sv
// Sequencing state machine of the text console.
module tcon_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tcon_pkg::t_status i_status,
    output logic              o_in_ready,
    output tcon_pkg::t_op     o_op
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_TAB,
        S_ROW,
        S_HRD,
        S_HWR,
        S_MRD,
        S_MWR,
        S_BLANK,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = tcon_pkg::OP_NONE;
        unique case (r_state)
            S_CLEAR: begin
                o_op = tcon_pkg::OP_CLEAR;
                if (i_status.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = tcon_pkg::OP_CAPTURE;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_status.kind)
                    tcon_pkg::KIND_TAB: begin
                        o_op    = tcon_pkg::OP_TAB_INIT;
                        n_state = S_TAB;
                    end
                    tcon_pkg::KIND_READ: begin
                        o_op    = tcon_pkg::OP_READ;
                        n_state = S_READ;
                    end
                    default: begin
                        o_op    = tcon_pkg::OP_STEP;
                        n_state = S_ROW;
                    end
                endcase
            end
            S_TAB: begin
                if (i_status.tab_more) begin
                    o_op = tcon_pkg::OP_TAB_WR;
                end else begin
                    o_op    = tcon_pkg::OP_TAB_END;
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (i_status.pend_row && i_status.scroll_need) begin
                    o_op    = tcon_pkg::OP_SCROLL_BEGIN;
                    n_state = S_HRD;
                end else if (i_status.pend_row) begin
                    o_op    = tcon_pkg::OP_ROW_INC;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_HRD: begin
                o_op    = tcon_pkg::OP_HIST_RD;
                n_state = S_HWR;
            end
            S_HWR: begin
                o_op = tcon_pkg::OP_HIST_WR;
                if (i_status.hist_last) n_state = i_status.single_row ? S_BLANK : S_MRD;
                else n_state = S_HRD;
            end
            S_MRD: begin
                o_op    = tcon_pkg::OP_MOVE_RD;
                n_state = S_MWR;
            end
            S_MWR: begin
                o_op    = tcon_pkg::OP_MOVE_WR;
                n_state = i_status.move_last ? S_BLANK : S_MRD;
            end
            S_BLANK: begin
                o_op = tcon_pkg::OP_BLANK;
                if (i_status.blank_last) n_state = S_DONE;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_op    = tcon_pkg::OP_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

### rtl/core/tcon_dp.sv
// Datapath of the text console: registers, cell memories and result register.
module tcon_dp #(
    parameter int MAX_ROWS      = tcon_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = tcon_pkg::MAX_COLS_DEF,
    parameter int HISTORY_LINES = tcon_pkg::HISTORY_LINES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tcon_pkg::t_op                       i_op,
    output tcon_pkg::t_status                   o_status,
    input  logic                                i_cfg_valid,
    input  logic [tcon_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcon_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [tcon_pkg::CMD_W-1:0]          i_in_user,
    input  logic [tcon_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic                                o_out_user,
    output logic [tcon_pkg::OUT_DATA_W-1:0]     o_out_data
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int HIS_W  = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
    localparam int FILL_W = $clog2(HISTORY_LINES + 1);
    localparam int RC     = ROW_W + 1;
    localparam int CC     = COL_W + 1;
    localparam int SA_W   = ROW_W + COL_W;
    localparam int HA_W   = HIS_W + COL_W;
    localparam int SCR_DEPTH = MAX_ROWS << COL_W;
    localparam int HIS_DEPTH = HISTORY_LINES << COL_W;
    localparam int M1 = (FILL_W > RC) ? FILL_W : RC;
    localparam int M2 = (M1 > CC) ? M1 : CC;
    localparam int M3 = (M2 > tcon_pkg::VCOL_W) ? M2 : tcon_pkg::VCOL_W;
    localparam int CW = M3 + 1;

    tcon_pkg::t_cell r_scr_mem [SCR_DEPTH];
    tcon_pkg::t_cell r_his_mem [HIS_DEPTH];

    logic [tcon_pkg::IW_W-1:0]     r_width_raw;
    logic [tcon_pkg::IH_W-1:0]     r_height_raw;
    logic [ROW_W-1:0]              r_row;
    logic [COL_W-1:0]              r_col;
    logic [FILL_W-1:0]             r_voff;
    logic [HIS_W-1:0]              r_head;
    logic [FILL_W-1:0]             r_fill;
    logic                          r_pend;
    logic [CC-1:0]                 r_stop;
    logic [ROW_W-1:0]              r_it_row;
    logic [COL_W-1:0]              r_it_col;
    logic [SA_W-1:0]               r_clr;
    logic [tcon_pkg::CMD_W-1:0]    r_cmd;
    logic [tcon_pkg::CHAR_W-1:0]   r_chr;
    logic [tcon_pkg::COLOUR_W-1:0] r_fg;
    logic [tcon_pkg::COLOUR_W-1:0] r_bg;
    logic [tcon_pkg::VROW_W-1:0]   r_vrow;
    logic [tcon_pkg::VCOL_W-1:0]   r_vcol;
    logic                          r_hit;
    logic                          r_hist;
    tcon_pkg::t_cell               r_scr_q;
    tcon_pkg::t_cell               r_his_q;
    logic                          r_out_valid;
    logic                          r_out_user;
    logic [tcon_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [CC-1:0] w;
    logic [RC-1:0] h;
    logic [RC-1:0] row_next;
    logic [CC-1:0] col_c;
    logic [CC-1:0] col_inc;
    logic          is_put;
    logic          is_erase;
    logic          is_print;
    logic          col_end;

    logic [CW-1:0] vr;
    logic [CW-1:0] voffc;
    logic [CW-1:0] back;
    logic [CW-1:0] headc;
    logic [CW-1:0] idx;
    logic [CW-1:0] live;
    logic          in_win;
    logic          use_hist;

    logic            scr_we;
    logic [SA_W-1:0] scr_wa;
    tcon_pkg::t_cell scr_wd;
    logic            scr_re;
    logic [SA_W-1:0] scr_ra;
    logic            his_re;
    logic [HA_W-1:0] his_ra;
    tcon_pkg::t_cell out_cell;

    always_comb begin
        if (r_width_raw == '0) w = CC'(1);
        else if (9'(r_width_raw) > 9'(MAX_COLS)) w = CC'(MAX_COLS);
        else w = CC'(r_width_raw);
        if (r_height_raw == '0) h = RC'(1);
        else if (9'(r_height_raw) > 9'(MAX_ROWS)) h = RC'(MAX_ROWS);
        else h = RC'(r_height_raw);
    end

    assign row_next = RC'(r_row) + RC'(1);
    assign col_c    = CC'(r_col);
    assign col_inc  = col_c + CC'(1);
    assign is_put   = (r_cmd == tcon_pkg::CMD_PUT_CHAR);
    assign is_erase = (r_chr == tcon_pkg::CH_BS) || (r_chr == tcon_pkg::CH_DEL);
    assign is_print = (r_chr >= tcon_pkg::CH_PRINT_LO) && (r_chr <= tcon_pkg::CH_PRINT_HI);
    assign col_end  = (CC'(r_it_col) == w - CC'(1));

    assign vr       = CW'(r_vrow);
    assign voffc    = CW'(r_voff);
    assign back     = voffc - vr;
    assign headc    = CW'(r_head);
    assign in_win   = (vr < CW'(h)) && (CW'(r_vcol) < CW'(w));
    assign use_hist = (vr < voffc) && (back <= CW'(r_fill));
    assign idx      = (headc >= back) ? (headc - back) : (headc + CW'(HISTORY_LINES) - back);
    assign live     = (vr >= voffc) ? (vr - voffc) : vr;

    always_comb begin
        o_status.clear_last  = (r_clr == SA_W'(SCR_DEPTH - 1));
        if (is_put && (r_chr == tcon_pkg::CH_TAB)) o_status.kind = tcon_pkg::KIND_TAB;
        else if (r_cmd == tcon_pkg::CMD_READ_CELL) o_status.kind = tcon_pkg::KIND_READ;
        else o_status.kind = tcon_pkg::KIND_STEP;
        o_status.tab_more    = (col_c < r_stop) && (col_c < w);
        o_status.pend_row    = r_pend;
        o_status.scroll_need = (row_next >= h);
        o_status.hist_last   = (r_it_col == COL_W'(MAX_COLS - 1));
        o_status.single_row  = (h == RC'(1));
        o_status.move_last   = col_end && (RC'(r_it_row) == h - RC'(2));
        o_status.blank_last  = col_end;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    always_comb begin
        scr_we = 1'b0;
        scr_wa = {r_row, r_col};
        scr_wd = tcon_pkg::BLANK_CELL;
        scr_re = 1'b0;
        scr_ra = {r_it_row, r_it_col};
        his_re = 1'b0;
        his_ra = {HIS_W'(idx), COL_W'(r_vcol)};
        case (i_op)
            tcon_pkg::OP_CLEAR: begin
                scr_we = 1'b1;
                scr_wa = r_clr;
            end
            tcon_pkg::OP_STEP: begin
                if (is_put && is_erase && (r_col != '0)) begin
                    scr_we = 1'b1;
                    scr_wa = {r_row, r_col - COL_W'(1)};
                end else if (is_put && is_print) begin
                    scr_we = 1'b1;
                    scr_wd = '{ch: r_chr, fg: r_fg, bg: r_bg};
                end
            end
            tcon_pkg::OP_TAB_WR: begin
                scr_we = 1'b1;
                scr_wd = '{ch: tcon_pkg::BLANK_CHAR, fg: r_fg, bg: r_bg};
            end
            tcon_pkg::OP_MOVE_WR: begin
                scr_we = 1'b1;
                scr_wa = {r_it_row, r_it_col};
                scr_wd = r_scr_q;
            end
            tcon_pkg::OP_BLANK: begin
                scr_we = 1'b1;
                scr_wa = {ROW_W'(h - RC'(1)), r_it_col};
            end
            tcon_pkg::OP_READ: begin
                scr_re = 1'b1;
                scr_ra = {ROW_W'(live), COL_W'(r_vcol)};
                his_re = 1'b1;
            end
            tcon_pkg::OP_HIST_RD: begin
                scr_re = 1'b1;
                scr_ra = {ROW_W'(0), r_it_col};
            end
            tcon_pkg::OP_MOVE_RD: begin
                scr_re = 1'b1;
                scr_ra = {ROW_W'(RC'(r_it_row) + RC'(1)), r_it_col};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) r_scr_mem[scr_wa] <= scr_wd;
        if (scr_re) r_scr_q <= r_scr_mem[scr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (i_op == tcon_pkg::OP_HIST_WR) r_his_mem[{r_head, r_it_col}] <= r_scr_q;
        if (his_re) r_his_q <= r_his_mem[his_ra];
    end

    always_comb begin
        out_cell = r_hist ? r_his_q : r_scr_q;
        if (!r_hit) out_cell = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= tcon_pkg::WIDTH_RST;
            r_height_raw <= tcon_pkg::HEIGHT_RST;
            r_row        <= '0;
            r_col        <= '0;
            r_voff       <= '0;
            r_head       <= '0;
            r_fill       <= '0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tcon_pkg::CFG_WIN_COLS: r_width_raw  <= i_cfg_data;
                    tcon_pkg::CFG_WIN_ROWS: r_height_raw <= i_cfg_data[tcon_pkg::IH_W-1:0];
                    default: ;
                endcase
            end
            if (i_op == tcon_pkg::OP_RESULT) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (i_op)
                tcon_pkg::OP_CLEAR: r_clr <= r_clr + SA_W'(1);
                tcon_pkg::OP_CAPTURE: begin
                    r_cmd  <= i_in_user;
                    r_chr  <= i_in_data[7:0];
                    r_fg   <= i_in_data[15:8];
                    r_bg   <= i_in_data[23:16];
                    r_vrow <= i_in_data[29:24];
                    r_vcol <= i_in_data[36:30];
                    r_hit  <= 1'b0;
                    r_hist <= 1'b0;
                    r_pend <= 1'b0;
                end
                tcon_pkg::OP_STEP: begin
                    if (is_put) begin
                        r_voff <= '0;
                        if (r_chr == tcon_pkg::CH_CR) begin
                            r_col <= '0;
                        end else if (r_chr == tcon_pkg::CH_LF) begin
                            r_pend <= 1'b1;
                        end else if (is_erase) begin
                            if (r_col != '0) r_col <= r_col - COL_W'(1);
                        end else if (is_print) begin
                            if (col_inc >= w) begin
                                r_col  <= '0;
                                r_pend <= 1'b1;
                            end else begin
                                r_col <= COL_W'(col_inc);
                            end
                        end
                    end else if (r_cmd == tcon_pkg::CMD_VIEW_UP) begin
                        if (r_voff < r_fill) r_voff <= r_voff + FILL_W'(1);
                    end else if (r_cmd == tcon_pkg::CMD_VIEW_DOWN) begin
                        if (r_voff != '0) r_voff <= r_voff - FILL_W'(1);
                    end else if (r_cmd == tcon_pkg::CMD_VIEW_RESET) begin
                        r_voff <= '0;
                    end
                end
                tcon_pkg::OP_TAB_INIT: begin
                    r_voff <= '0;
                    r_stop <= (col_c + CC'(tcon_pkg::TAB_STEP)) & ~CC'(tcon_pkg::TAB_STEP - 1);
                end
                tcon_pkg::OP_TAB_WR: begin
                    if (col_inc >= w) begin
                        r_col  <= '0;
                        r_stop <= '0;
                        r_pend <= 1'b1;
                    end else begin
                        r_col <= COL_W'(col_inc);
                    end
                end
                tcon_pkg::OP_TAB_END: begin
                    if (col_c >= w) begin
                        r_col  <= '0;
                        r_pend <= 1'b1;
                    end
                end
                tcon_pkg::OP_READ: begin
                    r_hit  <= in_win;
                    r_hist <= in_win && use_hist;
                end
                tcon_pkg::OP_ROW_INC: r_row <= ROW_W'(row_next);
                tcon_pkg::OP_SCROLL_BEGIN: r_it_col <= '0;
                tcon_pkg::OP_HIST_WR: begin
                    if (o_status.hist_last) begin
                        r_it_col <= '0;
                        r_it_row <= '0;
                        r_head   <= (r_head == HIS_W'(HISTORY_LINES - 1)) ? '0
                                                                         : r_head + HIS_W'(1);
                        if (r_fill < FILL_W'(HISTORY_LINES)) r_fill <= r_fill + FILL_W'(1);
                    end else begin
                        r_it_col <= r_it_col + COL_W'(1);
                    end
                end
                tcon_pkg::OP_MOVE_WR: begin
                    if (col_end) begin
                        r_it_col <= '0;
                        r_it_row <= r_it_row + ROW_W'(1);
                    end else begin
                        r_it_col <= r_it_col + COL_W'(1);
                    end
                end
                tcon_pkg::OP_BLANK: begin
                    r_it_col <= r_it_col + COL_W'(1);
                    if (col_end) r_row <= ROW_W'(h - RC'(1));
                end
                tcon_pkg::OP_RESULT: begin
                    r_out_user  <= r_hit && r_hist;
                    r_out_data  <= {tcon_pkg::VOFF_W'(r_voff), tcon_pkg::CCOL_W'(r_col),
                                    tcon_pkg::CROW_W'(r_row), out_cell.bg, out_cell.fg,
                                    out_cell.ch};
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_user;
    assign o_out_data  = r_out_data;

endmodule

### rtl/core/text_console_with_scrollback.sv
// Top level of the text console cell buffer with scrollback ring.
//
// Channel  Direction  Handshake             Payload
// s        in         i_s_tvalid/o_s_tready tuser command, tdata cell request
// m        out        o_m_tvalid/i_m_tready tuser from_history, tdata cell and state
// cfg      in         i_cfg_valid/o_cfg_ready index 0 window width, 1 window height
//
// One item at a time, in steps capture, execute, row (read for reads) and done; a tab
// first writes one cell per column it fills. A scroll adds a copy of all MAX_COLS
// cells of row 0 to history, a shift of rows 1 to h-1 up and a blank of row h-1.
// After reset a clearing pass over all MAX_ROWS*2^clog2(MAX_COLS) cells (8192 by
// default) blanks the screen; no item is taken meanwhile, configuration writes are.
// A result waiting on the output holds the following item in its last cycle.
module text_console_with_scrollback #(
    parameter int MAX_ROWS      = tcon_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS      = tcon_pkg::MAX_COLS_DEF,
    parameter int HISTORY_LINES = tcon_pkg::HISTORY_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // command
    input  logic [tcon_pkg::CMD_W-1:0]      i_s_tuser,
    // char_code, fore_colour, back_colour, view_row, view_col, zero pad
    input  logic [tcon_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // from_history
    output logic                            o_m_tuser,
    // cell_char, cell_fore, cell_back, cursor_row_now, cursor_col_now, view_offset_now
    output logic [tcon_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tcon_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcon_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    tcon_pkg::t_op     op;
    tcon_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    tcon_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_status   (status),
        .o_in_ready (o_s_tready),
        .o_op       (op)
    );

    tcon_dp #(
        .MAX_ROWS      (MAX_ROWS),
        .MAX_COLS      (MAX_COLS),
        .HISTORY_LINES (HISTORY_LINES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (i_s_tuser),
        .i_in_data   (i_s_tdata),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_user  (o_m_tuser),
        .o_out_data  (o_m_tdata)
    );

endmodule

### sim/text_console_checker.sv
// Checker for the text console: watches all channels, predicts each result and compares.
`timescale 1ns / 1ps

module text_console_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [tcon_pkg::CMD_W-1:0]      i_s_tuser,
    input  logic [tcon_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic                            i_m_tuser,
    input  logic [tcon_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [tcon_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcon_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int ROWS  = tcon_pkg::MAX_ROWS_DEF;
    localparam int COLS  = tcon_pkg::MAX_COLS_DEF;
    localparam int HLINE = tcon_pkg::HISTORY_LINES_DEF;

    typedef struct packed {
        tcon_pkg::t_cell             disp;
        logic                        hist;
        logic [tcon_pkg::CROW_W-1:0] row;
        logic [tcon_pkg::CCOL_W-1:0] col;
        logic [tcon_pkg::VOFF_W-1:0] off;
    } t_console_view;

    tcon_pkg::t_cell screen[ROWS][COLS];
    tcon_pkg::t_cell history[HLINE][COLS];
    int unsigned     width_reg, height_reg, head, fill, offset, cur_row, cur_col;
    t_console_view   view_queue[$];

    initial begin
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++) screen[r][c] = tcon_pkg::BLANK_CELL;
        for (int r = 0; r < HLINE; r++)
            for (int c = 0; c < COLS; c++) history[r][c] = tcon_pkg::BLANK_CELL;
        width_reg = 32'(tcon_pkg::WIDTH_RST);
        height_reg = 32'(tcon_pkg::HEIGHT_RST);
        head = 0;
        fill = 0;
        offset = 0;
        cur_row = 0;
        cur_col = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    function automatic int unsigned used_width();
        if (width_reg < 1) return 1;
        if (width_reg > COLS) return COLS;
        return width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg < 1) return 1;
        if (height_reg > ROWS) return ROWS;
        return height_reg;
    endfunction

    task automatic write_cell(int unsigned r, int unsigned c, tcon_pkg::t_cell v);
        if (r < ROWS && c < COLS) screen[r][c] = v;
    endtask

    task automatic scroll_up();
        int unsigned w, h;
        w = used_width();
        h = used_height();
        for (int c = 0; c < COLS; c++) history[head][c] = screen[0][c];
        head = (head + 1) % HLINE;
        if (fill < HLINE) fill++;
        for (int unsigned r = 0; r + 1 < h; r++)
            for (int unsigned c = 0; c < w; c++) screen[r][c] = screen[r+1][c];
        for (int unsigned c = 0; c < w; c++) write_cell(h - 1, c, tcon_pkg::BLANK_CELL);
    endtask

    task automatic line_feed();
        cur_row++;
        if (cur_row >= used_height()) begin
            scroll_up();
            cur_row = used_height() - 1;
        end
    endtask

    task automatic print_byte(logic [7:0] ch, logic [7:0] fg, logic [7:0] bg);
        int unsigned w, stop;
        w = used_width();
        offset = 0;
        if (ch == tcon_pkg::CH_CR) begin
            cur_col = 0;
        end else if (ch == tcon_pkg::CH_LF) begin
            line_feed();
        end else if (ch == tcon_pkg::CH_TAB) begin
            stop = (cur_col + tcon_pkg::TAB_STEP) & ~(tcon_pkg::TAB_STEP - 1);
            while (cur_col < stop && cur_col < w) begin
                write_cell(cur_row, cur_col, '{ch: tcon_pkg::BLANK_CHAR, fg: fg, bg: bg});
                cur_col++;
            end
            if (cur_col >= w) begin
                cur_col = 0;
                line_feed();
            end
        end else if (ch == tcon_pkg::CH_BS || ch == tcon_pkg::CH_DEL) begin
            if (cur_col > 0) begin
                cur_col--;
                write_cell(cur_row, cur_col, tcon_pkg::BLANK_CELL);
            end
        end else if (ch >= tcon_pkg::CH_PRINT_LO && ch <= tcon_pkg::CH_PRINT_HI) begin
            write_cell(cur_row, cur_col, '{ch: ch, fg: fg, bg: bg});
            cur_col++;
            if (cur_col >= w) begin
                cur_col = 0;
                line_feed();
            end
        end
    endtask

    task automatic look_up_cell(int unsigned r, int unsigned c, ref t_console_view v);
        int unsigned live, back;
        live = r;
        if (r >= used_height() || c >= used_width()) return;
        if (offset > 0) begin
            if (r < offset) begin
                back = offset - r;
                if (back <= fill && back <= HLINE) begin
                    v.disp = history[(head + HLINE - back) % HLINE][c];
                    v.hist = 1'b1;
                    return;
                end
            end else begin
                live = r - offset;
            end
        end
        if (live < ROWS) v.disp = screen[live][c];
    endtask

    task automatic predict_step(logic [tcon_pkg::CMD_W-1:0] cmd,
                                logic [tcon_pkg::IN_DATA_W-1:0] d);
        t_console_view v;
        v = '0;
        case (cmd)
            tcon_pkg::CMD_PUT_CHAR:   print_byte(d[7:0], d[15:8], d[23:16]);
            tcon_pkg::CMD_VIEW_UP:    if (offset < fill) offset++;
            tcon_pkg::CMD_VIEW_DOWN:  if (offset > 0) offset--;
            tcon_pkg::CMD_VIEW_RESET: offset = 0;
            tcon_pkg::CMD_READ_CELL:  look_up_cell(32'(d[29:24]), 32'(d[36:30]), v);
            default: ;
        endcase
        v.row = cur_row[tcon_pkg::CROW_W-1:0];
        v.col = cur_col[tcon_pkg::CCOL_W-1:0];
        v.off = offset[tcon_pkg::VOFF_W-1:0];
        view_queue.push_back(v);
    endtask

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, field, got, want);
        o_fail_count++;
    endtask

    task automatic compare_result();
        t_console_view e;
        if (view_queue.size() == 0) begin
            $display("%0t unexpected result transaction %h", $realtime, i_m_tdata);
            o_fail_count++;
            return;
        end
        e = view_queue.pop_front();
        if (i_m_tdata[7:0] !== e.disp.ch)
            report_mismatch("cell_char", 32'(i_m_tdata[7:0]), 32'(e.disp.ch));
        if (i_m_tdata[15:8] !== e.disp.fg)
            report_mismatch("cell_fore", 32'(i_m_tdata[15:8]), 32'(e.disp.fg));
        if (i_m_tdata[23:16] !== e.disp.bg)
            report_mismatch("cell_back", 32'(i_m_tdata[23:16]), 32'(e.disp.bg));
        if (i_m_tuser !== e.hist)
            report_mismatch("from_history", 32'(i_m_tuser), 32'(e.hist));
        if (i_m_tdata[29:24] !== e.row)
            report_mismatch("cursor_row", 32'(i_m_tdata[29:24]), 32'(e.row));
        if (i_m_tdata[36:30] !== e.col)
            report_mismatch("cursor_col", 32'(i_m_tdata[36:30]), 32'(e.col));
        if (i_m_tdata[47:37] !== e.off)
            report_mismatch("view_offset", 32'(i_m_tdata[47:37]), 32'(e.off));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) compare_result();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == tcon_pkg::CFG_WIN_COLS) width_reg = 32'(i_cfg_data);
                else height_reg = 32'(i_cfg_data[6:0]);
            end
            if (i_s_tvalid && i_s_tready) predict_step(i_s_tuser, i_s_tdata);
            o_pending = view_queue.size();
        end
    end

endmodule

### sim/text_console_with_scrollback_test.sv
// Top of the text console testbench: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps

module text_console_with_scrollback_test;

    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int SETTLE       = 17_000;
    localparam int LONG_HOLD    = 3_000;
    localparam logic [tcon_pkg::CMD_W-1:0] CMD_LAST  = '1;
    localparam logic [tcon_pkg::CMD_W-1:0] CMD_SPARE = tcon_pkg::CMD_READ_CELL + 3'd1;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [tcon_pkg::CMD_W-1:0]      i_s_tuser = '0;
    logic [tcon_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic                            o_m_tuser;
    logic [tcon_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tcon_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [tcon_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    int fail_count, pending;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;
    logic hold_done = 1'b0;

    always #6 i_clk = ~i_clk;

    text_console_with_scrollback uut (.*);

    text_console_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tuser(i_s_tuser),
        .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tuser(o_m_tuser),
        .i_m_tdata(o_m_tdata),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[text_console_with_scrollback] ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom % 100) >= recv_stall_pct;
        end
    end

    task automatic send(logic [tcon_pkg::CMD_W-1:0] cmd, logic [7:0] ch, logic [7:0] fg,
                        logic [7:0] bg, logic [5:0] vr, logic [6:0] vc);
        while (($urandom % 100) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {3'b0, vc, vr, bg, fg, ch};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic put(logic [7:0] ch);
        send(tcon_pkg::CMD_PUT_CHAR, ch, 8'($urandom), 8'($urandom), 6'($urandom),
             7'($urandom));
    endtask

    task automatic read_at(logic [5:0] vr, logic [6:0] vc);
        send(tcon_pkg::CMD_READ_CELL, 8'($urandom), 8'($urandom), 8'($urandom), vr, vc);
    endtask

    task automatic send_plain(logic [tcon_pkg::CMD_W-1:0] cmd);
        send(cmd, 8'($urandom), 8'($urandom), 8'($urandom), 6'($urandom), 7'($urandom));
    endtask

    task automatic quiesce();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_size(logic [7:0] w, logic [7:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tcon_pkg::CFG_WIN_COLS;
        i_cfg_data <= w;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= tcon_pkg::CFG_WIN_ROWS;
        i_cfg_data <= h;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_item(int unsigned w, int unsigned h);
        int unsigned pick, sel;
        logic [7:0] ch;
        pick = $urandom % 100;
        if (pick < 55) begin
            sel = $urandom % 100;
            if (sel < 60) begin
                ch = 8'($urandom_range(tcon_pkg::CH_PRINT_HI, tcon_pkg::CH_PRINT_LO));
            end else if (sel < 85) begin
                case ($urandom % 5)
                    0: ch = tcon_pkg::CH_CR;
                    1: ch = tcon_pkg::CH_LF;
                    2: ch = tcon_pkg::CH_TAB;
                    3: ch = tcon_pkg::CH_BS;
                    default: ch = tcon_pkg::CH_DEL;
                endcase
            end else begin
                ch = 8'($urandom);
            end
            put(ch);
        end else if (pick < 67) begin
            send_plain(tcon_pkg::CMD_VIEW_UP);
        end else if (pick < 74) begin
            send_plain(tcon_pkg::CMD_VIEW_DOWN);
        end else if (pick < 77) begin
            send_plain(tcon_pkg::CMD_VIEW_RESET);
        end else if (pick < 98) begin
            if ($urandom % 4 == 0) read_at(6'($urandom), 7'($urandom));
            else read_at(6'($urandom_range(h, 0)), 7'($urandom_range(w, 0)));
        end else begin
            send_plain(3'($urandom_range(CMD_LAST, CMD_SPARE)));
        end
    endtask

    task automatic run_phase(logic [7:0] w, logic [7:0] h, int n, int idle, int stall);
        int unsigned ew, eh, hm;
        hm = 32'(h[6:0]);
        ew = (w == 0) ? 1 : (w > tcon_pkg::MAX_COLS_DEF ? tcon_pkg::MAX_COLS_DEF : 32'(w));
        eh = (hm == 0) ? 1 : (hm > tcon_pkg::MAX_ROWS_DEF ? tcon_pkg::MAX_ROWS_DEF : hm);
        set_size(w, h);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < n; i++) random_item(ew, eh);
        quiesce();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_size(8'd10, 8'd2);
        send(tcon_pkg::CMD_PUT_CHAR, 8'd65, 8'hff, 8'h00, 6'd0, 7'd0);
        send(tcon_pkg::CMD_PUT_CHAR, tcon_pkg::CH_PRINT_HI, 8'h00, 8'hff, 6'h3f, 7'h7f);
        send(tcon_pkg::CMD_PUT_CHAR, tcon_pkg::CH_PRINT_LO, 8'haa, 8'h55, 6'd0, 7'd0);
        put(8'd0);
        put(8'd255);
        put(8'd128);
        put(tcon_pkg::CH_TAB);
        put(tcon_pkg::CH_BS);
        put(tcon_pkg::CH_DEL);
        put(tcon_pkg::CH_CR);
        put(tcon_pkg::CH_BS);
        read_at(6'd0, 7'd0);
        read_at(6'd0, 7'd9);
        read_at(6'd1, 7'd10);
        read_at(6'h3f, 7'h7f);
        put(tcon_pkg::CH_LF);
        put(tcon_pkg::CH_LF);
        send(tcon_pkg::CMD_VIEW_UP, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        send(tcon_pkg::CMD_VIEW_UP, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        read_at(6'd0, 7'd0);
        read_at(6'd1, 7'd1);
        send(tcon_pkg::CMD_VIEW_DOWN, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        send(tcon_pkg::CMD_VIEW_DOWN, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        send(tcon_pkg::CMD_VIEW_UP, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        send(tcon_pkg::CMD_VIEW_RESET, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        send(CMD_SPARE, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        send(CMD_LAST, 8'd0, 8'd0, 8'd0, 6'd0, 7'd0);
        quiesce();

        run_phase(8'd1, 8'd1, 90, 0, 0);
        run_phase(8'd16, 8'd4, 140, 66, 0);
        run_phase(8'd0, 8'd0, 40, 0, 66);
        run_phase(8'd255, 8'hff, 40, 10, 10);
        run_phase(8'd128, 8'd64, 20, 0, 0);

        set_size(8'd12, 8'd3);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 200; i++) begin
            if (i == 20) hold_req <= 1'b1;
            random_item(12, 3);
        end
        quiesce();

        set_size(8'd8, 8'd2);
        for (int i = 0; i < 240; i++) begin
            send_idle_pct = (i < 120) ? 66 : 10;
            recv_stall_pct = (i < 60) ? 0 : 66;
            if (i == 100) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            random_item(8, 2);
        end
        i_s_tvalid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("[text_console_with_scrollback] OK");
        end else begin
            $display("[text_console_with_scrollback] ERROR");
        end
        $finish;
    end

endmodule

### text_console_with_scrollback.f
rtl/core/tcon_pkg.sv
rtl/core/tcon_ctrl.sv
rtl/core/tcon_dp.sv
rtl/core/text_console_with_scrollback.sv
sim/text_console_checker.sv
sim/text_console_with_scrollback_test.sv
